// ----- sv/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/wmcj_pkg.sv -----
// ----------------------------------------------------------------------------
// wmcj_pkg
// Types and constants of the windowed minimum-cost jump block.
// ----------------------------------------------------------------------------
`default_nettype none

package wmcj_pkg;

  localparam int unsigned HEIGHT_W = 16;
  localparam int unsigned COST_W   = 32;
  localparam int unsigned LIMIT_W  = 5;

  localparam logic [COST_W-1:0]  COST_MAX    = {COST_W{1'b1}};
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(2);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic shift;   // commit a request: window moves by one stone
    logic active;  // cell holds a predecessor that may be jumped from
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/wmcj_cell.sv -----
// ----------------------------------------------------------------------------
// wmcj_cell
// One window slot: stored stone, candidate cost and one step of the min chain.
// ----------------------------------------------------------------------------
`default_nettype none

module wmcj_cell (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire wmcj_pkg::cell_ctrl_t            ctrl_i,
  input  wire logic [wmcj_pkg::HEIGHT_W-1:0]   cur_height_i,
  input  wire logic [wmcj_pkg::HEIGHT_W-1:0]   height_i,
  input  wire logic [wmcj_pkg::COST_W-1:0]     cost_i,
  input  wire logic [wmcj_pkg::COST_W-1:0]     acc_i,
  output logic      [wmcj_pkg::HEIGHT_W-1:0]   height_o,
  output logic      [wmcj_pkg::COST_W-1:0]     cost_o,
  output logic      [wmcj_pkg::COST_W-1:0]     acc_o
);

  logic [wmcj_pkg::HEIGHT_W-1:0] height_q;
  logic [wmcj_pkg::COST_W-1:0]   cost_q;
  logic [wmcj_pkg::COST_W-1:0]   cand_q, cand_d;
  logic [wmcj_pkg::COST_W-1:0]   acc_q, acc_d;
  logic [wmcj_pkg::HEIGHT_W-1:0] diff;
  logic [wmcj_pkg::COST_W:0]     sum;

  always_comb begin
    if (cur_height_i >= height_q) begin
      diff = cur_height_i - height_q;
    end else begin
      diff = height_q - cur_height_i;
    end
    sum = {1'b0, cost_q} + (wmcj_pkg::COST_W + 1)'(diff);
    if (!ctrl_i.active || sum[wmcj_pkg::COST_W]) begin
      cand_d = wmcj_pkg::COST_MAX;
    end else begin
      cand_d = sum[wmcj_pkg::COST_W-1:0];
    end
    acc_d = (cand_q < acc_i) ? cand_q : acc_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= '0;
      cost_q   <= '0;
      cand_q   <= wmcj_pkg::COST_MAX;
      acc_q    <= wmcj_pkg::COST_MAX;
    end else begin
      if (ctrl_i.shift) begin
        height_q <= height_i;
        cost_q   <= cost_i;
      end
      cand_q <= cand_d;
      acc_q  <= acc_d;
    end
  end

  assign height_o = height_q;
  assign cost_o   = cost_q;
  assign acc_o    = acc_q;

endmodule

`default_nettype wire

// ----- sv/windowed_min_cost_jump_dp.sv -----
// ----------------------------------------------------------------------------
// windowed_min_cost_jump_dp
// Least cost to reach each stone, jumping 1..jump_limit stones per step.
// ----------------------------------------------------------------------------
//  channel   dir   payload                                  handshake
//  s_axis    in    tdata: height[15:0]; tuser: first_stone  tvalid/tready
//  m_axis    out   tdata: best_cost[31:0]                   tvalid/tready
//  cfg       in    cfg_data_i: jump_limit[4:0]              cfg_valid_i/cfg_ready_o
//
//  Each request passes through accept, a phase while the minimum ripples
//  down the row of cells, and a commit, before the next stone is taken.
//  The commit waits while the output register still holds an untaken result.
//  Reset clears the stone count and sets jump_limit to 2.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_min_cost_jump_dp #(
  parameter int unsigned MAX_JUMP = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // height[15:0]
  input  wire logic [0:0]  s_axis_tuser,   // first_stone[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,   // best_cost[31:0]
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [4:0]  cfg_data_i      // jump_limit[4:0]
);

  localparam int unsigned CntW   = $clog2(MAX_JUMP + 1);
  localparam int unsigned CmpW   = (CntW > wmcj_pkg::LIMIT_W) ? CntW : wmcj_pkg::LIMIT_W;
  localparam int unsigned CalcW  = $clog2(MAX_JUMP + 2);
  localparam logic [CalcW-1:0] CalcLast = CalcW'(MAX_JUMP);

  wmcj_pkg::state_e st_q, st_d;

  logic [wmcj_pkg::LIMIT_W-1:0]  jl_q;
  logic [CntW-1:0]               stones_q, stones_d;
  logic [CntW-1:0]               n_q, n_d;
  logic [CalcW-1:0]              cnt_q, cnt_d;
  logic [wmcj_pkg::HEIGHT_W-1:0] h_q;
  logic                          out_valid_q, out_valid_d;
  logic [wmcj_pkg::COST_W-1:0]   out_data_q;

  logic                          in_acc, commit;
  logic [CntW-1:0]               stones_eff;
  logic [CmpW-1:0]               lim, seen_ext;
  logic [wmcj_pkg::COST_W-1:0]   cost;

  logic [wmcj_pkg::HEIGHT_W-1:0] hgt [MAX_JUMP+1];
  logic [wmcj_pkg::COST_W-1:0]   cst [MAX_JUMP+1];
  logic [wmcj_pkg::COST_W-1:0]   acc [MAX_JUMP+1];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (st_q == wmcj_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign commit        = (st_q == wmcj_pkg::ST_DONE) && (!out_valid_q || m_axis_tready);

  // effective jump limit, clamped to 1..MAX_JUMP
  always_comb begin
    if (jl_q == '0) begin
      lim = CmpW'(1);
    end else if (CmpW'(jl_q) > CmpW'(MAX_JUMP)) begin
      lim = CmpW'(MAX_JUMP);
    end else begin
      lim = CmpW'(jl_q);
    end
    stones_eff = s_axis_tuser[0] ? '0 : stones_q;
    seen_ext   = CmpW'(stones_eff);
  end

  assign cost = (n_q == '0) ? '0 : acc[MAX_JUMP];

  always_comb begin
    st_d        = st_q;
    cnt_d       = cnt_q;
    stones_d    = stones_q;
    n_d         = n_q;
    out_valid_d = out_valid_q;
    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    case (st_q)
      wmcj_pkg::ST_IDLE: begin
        if (in_acc) begin
          stones_d = stones_eff;
          n_d      = (seen_ext < lim) ? stones_eff : CntW'(lim);
          cnt_d    = '0;
          st_d     = wmcj_pkg::ST_CALC;
        end
      end
      wmcj_pkg::ST_CALC: begin
        cnt_d = cnt_q + CalcW'(1);
        if (cnt_q == CalcLast) begin
          st_d = wmcj_pkg::ST_DONE;
        end
      end
      wmcj_pkg::ST_DONE: begin
        if (commit) begin
          out_valid_d = 1'b1;
          if (stones_q != CntW'(MAX_JUMP)) begin
            stones_d = stones_q + CntW'(1);
          end
          st_d = wmcj_pkg::ST_IDLE;
        end
      end
      default: begin
        st_d = wmcj_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= wmcj_pkg::ST_IDLE;
      jl_q        <= wmcj_pkg::LIMIT_RESET;
      stones_q    <= '0;
      n_q         <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      stones_q    <= stones_d;
      n_q         <= n_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        jl_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      h_q <= s_axis_tdata;
    end
    if (commit) begin
      out_data_q <= cost;
    end
  end

  assign hgt[0] = h_q;
  assign cst[0] = cost;
  assign acc[0] = wmcj_pkg::COST_MAX;

  for (genvar i = 0; i < MAX_JUMP; i++) begin : g_cell
    wmcj_pkg::cell_ctrl_t ctrl;
    assign ctrl = wmcj_pkg::cell_ctrl_t'{shift: commit, active: (CntW'(i) < n_q)};

    wmcj_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .cur_height_i (h_q),
      .height_i     (hgt[i]),
      .cost_i       (cst[i]),
      .acc_i        (acc[i]),
      .height_o     (hgt[i+1]),
      .cost_o       (cst[i+1]),
      .acc_o        (acc[i+1])
    );
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // last stone of the window falls off the end of the row
  logic [wmcj_pkg::HEIGHT_W-1:0] unused_h;
  logic [wmcj_pkg::COST_W-1:0]   unused_c;
  assign unused_h = hgt[MAX_JUMP];
  assign unused_c = cst[MAX_JUMP];

endmodule

`default_nettype wire

// ----- sv/wmcj_checker.sv -----
// ----------------------------------------------------------------------------
// wmcj_checker
// Port-level checks of the windowed minimum-cost jump block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module wmcj_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        cfg_ready_o
);

  // one request in flight: input closes right after an accept
  `ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // a new result only comes out of the commit, when the input was closed
  `ASSERT_IMPLY(a_result_after_work, clk_i, rst_ni, $rose(m_axis_tvalid), $past(!s_axis_tready))

  // stalled result holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // register port never stalls
  `ASSERT_IMPLY(a_cfg_open, clk_i, rst_ni, 1'b1, cfg_ready_o)

endmodule

bind windowed_min_cost_jump_dp wmcj_checker u_wmcj_checker (.*);

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream test of windowed_min_cost_jump_dp.
// A directed table of stones and jump_limit writes runs first. A long run of
// random stone sequences follows, spread over phases with different limits
// and different sender and receiver idling. Every cost is checked, in order,
// against a typed cost or a local predictor of the windowed minimum-cost recurrence.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned MAX_JUMP      = 16;
  localparam int unsigned PIPE_CYCLES   = MAX_JUMP + 3;
  localparam int unsigned RANDOM_STONES = 720;
  localparam int unsigned NUM_PHASES    = 8;
  localparam int unsigned CYCLE_LIMIT   = 600_000;

  typedef enum logic {ROW_STONE, ROW_LIMIT} row_kind_e;

  typedef struct {
    row_kind_e                           kind;
    logic [wmcj_pkg::HEIGHT_W-1:0]       height;
    logic                                first;
    logic                                typed;   // cost below is typed in, not predicted
    logic [wmcj_pkg::COST_W-1:0]         cost;
    logic [wmcj_pkg::LIMIT_W-1:0]        limit;
  } dir_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata  = '0;   // height[15:0]
  logic [0:0]          s_axis_tuser  = '0;   // first_stone[0]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [31:0]         m_axis_tdata;         // best_cost[31:0]
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [4:0]          cfg_data_i    = '0;   // jump_limit[4:0]

  // Predictor state
  logic [wmcj_pkg::HEIGHT_W-1:0] prev_heights [MAX_JUMP];
  logic [wmcj_pkg::COST_W-1:0]   prev_costs   [MAX_JUMP];
  int unsigned                   run_stones;
  logic [wmcj_pkg::LIMIT_W-1:0]  jump_limit_q = wmcj_pkg::LIMIT_RESET;

  logic [wmcj_pkg::COST_W-1:0]   pending_costs [$];
  logic [wmcj_pkg::COST_W-1:0]   want_cost;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned error_count    = 0;
  int unsigned stones_sent    = 0;
  int unsigned sequences_sent = 0;
  int unsigned limit_writes   = 0;
  int unsigned costs_checked  = 0;
  int unsigned cycle_count    = 0;

  always #10 clk_i = ~clk_i;

  windowed_min_cost_jump_dp #(
    .MAX_JUMP(MAX_JUMP)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  task automatic flag_mismatch(input string msg);
    error_count++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Least cost to reach this stone; shifts the stone into the window.
  function automatic logic [wmcj_pkg::COST_W-1:0] cost_of_stone(
      input logic [wmcj_pkg::HEIGHT_W-1:0] height, input logic first);
    int unsigned                   span;
    int unsigned                   reach;
    logic [wmcj_pkg::COST_W:0]     best;
    logic [wmcj_pkg::COST_W:0]     cand;
    logic [wmcj_pkg::HEIGHT_W-1:0] diff;
    logic [wmcj_pkg::COST_W-1:0]   cost;
    if (first) run_stones = 0;
    span = (jump_limit_q == 0) ? 1 : int'(jump_limit_q);
    if (span > MAX_JUMP) span = MAX_JUMP;
    reach = (run_stones < span) ? run_stones : span;
    if (reach == 0) begin
      cost = '0;
    end else begin
      best = {1'b0, wmcj_pkg::COST_MAX};
      for (int i = 0; i < reach; i++) begin
        diff = (height >= prev_heights[i]) ? height - prev_heights[i]
                                           : prev_heights[i] - height;
        cand = {1'b0, prev_costs[i]} + (wmcj_pkg::COST_W + 1)'(diff);
        if (cand > {1'b0, wmcj_pkg::COST_MAX}) cand = {1'b0, wmcj_pkg::COST_MAX};
        if (cand < best) best = cand;
      end
      cost = best[wmcj_pkg::COST_W-1:0];
    end
    for (int i = MAX_JUMP - 1; i > 0; i--) begin
      prev_heights[i] = prev_heights[i-1];
      prev_costs[i]   = prev_costs[i-1];
    end
    prev_heights[0] = height;
    prev_costs[0]   = cost;
    if (run_stones < MAX_JUMP) run_stones++;
    return cost;
  endfunction

  // Drop tvalid and hold off until every cost has come back.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_costs.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_stone(input logic [wmcj_pkg::HEIGHT_W-1:0] height, input logic first,
                            input logic typed, input logic [wmcj_pkg::COST_W-1:0] typed_cost);
    logic [wmcj_pkg::COST_W-1:0] predicted;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= height;
    s_axis_tuser  <= first;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = cost_of_stone(height, first);
    pending_costs = {pending_costs, (typed ? typed_cost : predicted)};
    stones_sent++;
    if (first) sequences_sent++;
  endtask

  task automatic write_limit(input logic [wmcj_pkg::LIMIT_W-1:0] value);
    wait_for_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i  <= 1'b0;
    jump_limit_q = value;
    limit_writes++;
  endtask

  function automatic dir_row_t mk_stone(input logic [wmcj_pkg::HEIGHT_W-1:0] height,
                                        input logic first, input logic typed,
                                        input logic [wmcj_pkg::COST_W-1:0] cost);
    dir_row_t r;
    r.kind   = ROW_STONE;
    r.height = height;
    r.first  = first;
    r.typed  = typed;
    r.cost   = cost;
    r.limit  = '0;
    return r;
  endfunction

  function automatic dir_row_t mk_limit(input logic [wmcj_pkg::LIMIT_W-1:0] value);
    dir_row_t r;
    r.kind   = ROW_LIMIT;
    r.height = '0;
    r.first  = 1'b0;
    r.typed  = 1'b0;
    r.cost   = '0;
    r.limit  = value;
    return r;
  endfunction

  // Output side: random stalls, in-order compare of each taken cost.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_costs.size() == 0) begin
        flag_mismatch($sformatf("cost %0d with no stone outstanding", m_axis_tdata));
      end else begin
        want_cost = pending_costs.pop_front();
        costs_checked++;
        if (m_axis_tdata !== want_cost) begin
          flag_mismatch($sformatf("best_cost %0d, predicted %0d", m_axis_tdata, want_cost));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d costs outstanding",
               cycle_count, pending_costs.size());
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    dir_row_t                      rows [$];
    int unsigned                   phase_sent;
    int unsigned                   seq_len;
    int unsigned                   style;
    int unsigned                   pick;
    logic                          lead_first;
    logic                          pressure_done;
    logic [wmcj_pkg::HEIGHT_W-1:0] h;
    logic [wmcj_pkg::LIMIT_W-1:0]  phase_limit;

    for (int i = 0; i < MAX_JUMP; i++) begin
      prev_heights[i] = '0;
      prev_costs[i]   = '0;
    end
    run_stones    = 0;
    pressure_done = 1'b0;
    h             = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rows = '{
      // reset limit of 2; first stone after reset has no predecessor
      mk_stone(16'd100,  1'b0, 1'b1, 32'd0),
      mk_stone(16'hFFFF, 1'b0, 1'b1, 32'd65435),
      mk_stone(16'h0000, 1'b0, 1'b0, '0),
      mk_stone(16'h0000, 1'b1, 1'b1, 32'd0),
      mk_stone(16'hFFFF, 1'b0, 1'b1, 32'd65535),
      // zero limit behaves as one
      mk_limit(5'd0),
      mk_stone(16'h0000, 1'b1, 1'b1, 32'd0),
      mk_stone(16'hFFFF, 1'b0, 1'b1, 32'd65535),
      mk_stone(16'h0000, 1'b0, 1'b1, 32'd131070),
      mk_stone(16'hFFFF, 1'b0, 1'b0, '0),
      // limit above the window clamps to MAX_JUMP; short history here
      mk_limit(5'd31),
      mk_stone(16'h0007, 1'b1, 1'b1, 32'd0),
      mk_stone(16'hAAAA, 1'b0, 1'b0, '0),
      mk_stone(16'h5555, 1'b0, 1'b0, '0),
      mk_stone(16'hFFFF, 1'b0, 1'b0, '0),
      mk_stone(16'h0000, 1'b0, 1'b0, '0),
      mk_stone(16'h8000, 1'b0, 1'b0, '0),
      mk_stone(16'h7FFF, 1'b0, 1'b0, '0),
      mk_limit(5'd16),
      mk_stone(16'h1234, 1'b0, 1'b0, '0),
      mk_stone(16'h0001, 1'b0, 1'b0, '0),
      mk_limit(5'd17),
      mk_stone(16'hFFFE, 1'b0, 1'b0, '0),
      mk_stone(16'h0000, 1'b0, 1'b0, '0),
      mk_limit(5'd1),
      mk_stone(16'h0003, 1'b0, 1'b0, '0)
    };
    foreach (rows[r]) begin
      if (rows[r].kind == ROW_LIMIT) begin
        write_limit(rows[r].limit);
      end else begin
        send_stone(rows[r].height, rows[r].first, rows[r].typed, rows[r].cost);
      end
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      case (phase)
        0: phase_limit = 5'd1;
        1: phase_limit = 5'd31;
        2: phase_limit = 5'd0;
        3: phase_limit = 5'd16;
        4: phase_limit = 5'd17;
        5: phase_limit = wmcj_pkg::LIMIT_W'($urandom_range(2, 15));
        6: phase_limit = 5'd2;
        default: phase_limit = wmcj_pkg::LIMIT_W'($urandom_range(0, 31));
      endcase
      write_limit(phase_limit);

      phase_sent = 0;
      while (phase_sent < RANDOM_STONES / NUM_PHASES) begin
        pick = $urandom_range(19);
        if (pick < 14) seq_len = $urandom_range(1, 12);
        else if (pick < 19) seq_len = $urandom_range(13, 40);
        else seq_len = $urandom_range(41, 90);
        style = $urandom_range(3);
        // most sequences open with the flag; a few carry on the last one
        lead_first = ($urandom_range(9) != 0);
        if ($urandom_range(63) == 0 || (phase == 1 && !pressure_done)) begin
          wait_for_results();
          pressure_done = 1'b1;
        end
        for (int k = 0; k < seq_len; k++) begin
          case (style)
            0: h = wmcj_pkg::HEIGHT_W'($urandom);
            1: h = $urandom_range(1) ? '1 : '0;
            2: h = h + wmcj_pkg::HEIGHT_W'($urandom_range(64)) - 16'd32;
            default: begin
              h = 16'd1 << $urandom_range(15);
              if ($urandom_range(1)) h = ~h;
            end
          endcase
          // stray restart inside a sequence now and then
          send_stone(h, (k == 0) ? lead_first : ($urandom_range(49) == 0), 1'b0, '0);
          phase_sent++;
        end
      end
    end

    wait_for_results();
    repeat (2 * PIPE_CYCLES) @(posedge clk_i);

    $display("Ran %0d stones in %0d flagged sequences across %0d jump_limit writes.",
             stones_sent, sequences_sent, limit_writes);
    $display("Compared %0d costs, %0d mismatches.", costs_checked, error_count);
    if (error_count == 0 && pending_costs.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ----- windowed_min_cost_jump_dp.f -----
+incdir+sv
sv/wmcj_pkg.sv
sv/wmcj_cell.sv
sv/windowed_min_cost_jump_dp.sv
sv/wmcj_checker.sv
dv/tb.sv
